// File: rtl/core/mi3_pkg.sv
`default_nettype none
package mi3_pkg;

    localparam int NE        = 9;    // elements in a 3x3 matrix
    localparam int MW        = 18;   // Q2.16 input element
    localparam int PW        = 2 * MW;
    localparam int CW        = 37;   // cofactor, Q5.32
    localparam int DW        = 55;   // determinant, units of 2^-48
    localparam int AW        = DW - 1;   // magnitude of determinant
    localparam int NW        = CW - 1;   // magnitude of cofactor
    localparam int QW        = 33;   // quotient bits before rounding
    localparam int OW        = 32;   // Q16.16 result element
    localparam int THW       = 16;
    localparam int DIV_STEPS = QW;
    localparam int SW        = $clog2(DIV_STEPS);
    localparam logic [THW-1:0] THR_RESET = 16'd43;

    typedef logic signed [MW-1:0] t_elem;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [CW-1:0] t_cof;
    typedef logic signed [DW-1:0] t_det;
    typedef logic signed [OW-1:0] t_out;

    // cofactor k = m[CA]*m[CB] - m[CC]*m[CD], row-major adjugate order
    localparam logic [3:0] CA [NE] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] CB [NE] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] CC [NE] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] CD [NE] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        t_cof [NE-1:0] cof;
        t_det          det;
        logic          singular;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

endpackage
`default_nettype wire

// File: rtl/core/matrix3x3_inverse.sv
// Channel   Direction  Payload
// s_axis    in         tdata: m00..m22, 18 bits each, from bit 0 up
// m_axis    out        tdata: inv00..inv22, 32 bits each; tuser: singular
// cfg       in         det_threshold, written on i_cfg_we
//
// The front forms cofactors and determinant in registered stages a to e
// and takes an item every cycle unless stage e waits on a full queue.
// The back divides all nine terms in parallel lanes, one quotient bit
// per cycle, one item at a time: pop, 33 divide steps (none if singular),
// output load. A 2-entry queue lets the front fill while the back divides;
// a stalled output holds the back. Reset is synchronous, active low.
`default_nettype none
module matrix3x3_inverse
    import mi3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire [167:0]  i_s_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22, pad
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [287:0] o_m_axis_tdata,   // inv00..inv22
    output logic         o_m_axis_tuser,   // singular
    input  wire          i_cfg_we,
    input  wire [15:0]   i_cfg_wdata
);
    logic [THW-1:0] r_det_threshold;
    t_elem          w_m [NE];
    logic           w_push, w_pop, w_full, w_empty;
    t_job           w_qin, w_qout;
    t_out [NE-1:0]  w_inv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_threshold <= THR_RESET;
        end else if (i_cfg_we) begin
            r_det_threshold <= i_cfg_wdata;
        end
    end

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            w_m[k] = signed'(i_s_axis_tdata[MW*k +: MW]);
        end
    end

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_m     (w_m),
        .i_thr   (r_det_threshold),
        .o_push  (w_push),
        .o_job   (w_qin),
        .i_full  (w_full)
    );

    mi3_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_qin),
        .i_pop   (w_pop),
        .o_job   (w_qout),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mi3_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_job      (w_qout),
        .o_pop      (w_pop),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_inv      (w_inv),
        .o_singular (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = w_inv;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_full && !w_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_empty))
        else $error("queue read while empty");
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("singular result carries nonzero data");
`endif
endmodule
`default_nettype wire

// File: rtl/core/mi3_queue.sv
`default_nettype none
module mi3_queue
    import mi3_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_job i_job,
    input  wire  i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);
    localparam int PTW = $clog2(DEPTH);
    localparam int CTW = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTW-1:0]   r_wr, r_rd;
    logic [CTW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CTW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    // store entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/mi3_front.sv
`default_nettype none
module mi3_front
    import mi3_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  t_elem           i_m [NE],
    input  wire [THW-1:0]   i_thr,
    output logic            o_push,
    output t_job            o_job,
    input  wire             i_full
);
    logic  w_en;
    logic  r_a_v, r_b_v, r_c_v, r_d_v, r_e_v;
    t_elem r_a_m [NE];
    t_prod r_b_p [2*NE];
    t_elem r_b_m [3];
    t_cof  r_c_cof [NE];
    t_elem r_c_m [3];
    t_det  r_d_pd [3];
    t_cof  r_d_cof [NE];
    t_det  r_e_det;
    t_cof  r_e_cof [NE];
    t_det  w_lim;
    logic  w_sing;

    // whole pipe holds while the last stage waits on a full queue
    assign w_en    = !r_e_v || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_e_v && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
        end
    end

    // products, cofactors, determinant terms, determinant
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_m <= i_m;
            for (int k = 0; k < NE; k++) begin
                r_b_p[2*k]   <= PW'(r_a_m[CA[k]]) * PW'(r_a_m[CB[k]]);
                r_b_p[2*k+1] <= PW'(r_a_m[CC[k]]) * PW'(r_a_m[CD[k]]);
                r_c_cof[k]   <= CW'(r_b_p[2*k]) - CW'(r_b_p[2*k+1]);
            end
            for (int j = 0; j < 3; j++) begin
                r_b_m[j]  <= r_a_m[j];
                r_c_m[j]  <= r_b_m[j];
                r_d_pd[j] <= DW'(r_c_m[j]) * DW'(r_c_cof[3*j]);
            end
            r_d_cof <= r_c_cof;
            r_e_det <= r_d_pd[0] + r_d_pd[1] + r_d_pd[2];
            r_e_cof <= r_d_cof;
        end
    end

    // classify: |det| below threshold * 2^16, or exactly zero
    assign w_lim  = signed'(DW'({i_thr, 16'h0000}));
    assign w_sing = (r_e_det == '0)
                 || (!r_e_det[DW-1] && (r_e_det < w_lim))
                 || (r_e_det[DW-1] && (r_e_det > -w_lim));

    always_comb begin
        for (int k = 0; k < NE; k++) begin
            o_job.cof[k] = r_e_cof[k];
        end
        o_job.det      = r_e_det;
        o_job.singular = w_sing;
    end
endmodule
`default_nettype wire

// File: rtl/core/mi3_back.sv
`default_nettype none
module mi3_back
    import mi3_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output t_out [NE-1:0]    o_inv,
    output logic             o_singular
);
    t_back_state r_state, n_state;
    logic [AW-1:0] r_d;
    logic [AW-1:0] r_rem [NE];
    logic [QW-1:0] r_q   [NE];
    logic [NE-1:0] r_neg, r_ovf, r_nlsb;
    logic          r_sing;
    logic [SW-1:0] r_cnt;
    logic          r_ov;
    t_out          r_inv [NE];
    logic          r_osing;
    logic          w_out_free;
    logic [AW-1:0] w_dabs;
    t_out          w_res [NE];

    assign w_out_free = !r_ov || i_ready;
    assign o_pop      = (r_state == BK_IDLE) && !i_empty;
    assign w_dabs     = i_job.det[DW-1] ? AW'(-i_job.det) : AW'(i_job.det);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_empty) begin
                    n_state = i_job.singular ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // load lanes, then one quotient bit per lane per cycle
    always_ff @(posedge i_clk) begin
        logic [NW-1:0] v_n;
        logic [AW:0]   v_t;
        if (o_pop) begin
            r_d    <= w_dabs;
            r_sing <= i_job.singular;
            r_cnt  <= SW'(DIV_STEPS - 1);
            for (int k = 0; k < NE; k++) begin
                v_n = i_job.cof[k][CW-1] ? NW'(-i_job.cof[k]) : NW'(i_job.cof[k]);
                r_neg[k]  <= i_job.cof[k][CW-1] ^ i_job.det[DW-1];
                r_ovf[k]  <= (DW'(v_n) >= {w_dabs, 1'b0});
                r_nlsb[k] <= v_n[0];
                r_rem[k]  <= AW'(v_n >> 1);
                r_q[k]    <= '0;
            end
        end else if (r_state == BK_DIV) begin
            r_cnt <= r_cnt - 1'b1;
            for (int k = 0; k < NE; k++) begin
                v_t = {r_rem[k], (r_cnt == SW'(DIV_STEPS - 1)) ? r_nlsb[k] : 1'b0};
                if (v_t >= {1'b0, r_d}) begin
                    r_rem[k] <= AW'(v_t - {1'b0, r_d});
                    r_q[k]   <= {r_q[k][QW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= v_t[AW-1:0];
                    r_q[k]   <= {r_q[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero, saturate, apply sign
    always_comb begin
        logic          v_rnd;
        logic [QW:0]   v_qr;
        logic [QW:0]   v_lim;
        logic [QW:0]   v_mag;
        for (int k = 0; k < NE; k++) begin
            v_rnd = ({r_rem[k], 1'b0} >= {1'b0, r_d});
            v_qr  = {1'b0, r_q[k]} + (QW + 1)'(v_rnd);
            v_lim = r_neg[k] ? (QW + 1)'(34'h080000000) : (QW + 1)'(34'h07FFFFFFF);
            v_mag = (r_ovf[k] || (v_qr > v_lim)) ? v_lim : v_qr;
            if (r_sing) begin
                w_res[k] = '0;
            end else if (r_neg[k]) begin
                w_res[k] = signed'(OW'(-v_mag[OW-1:0]));
            end else begin
                w_res[k] = signed'(v_mag[OW-1:0]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == BK_DONE) && w_out_free) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == BK_DONE) && w_out_free) begin
            r_inv   <= w_res;
            r_osing <= r_sing;
        end
    end

    assign o_valid    = r_ov;
    assign o_singular = r_osing;
    always_comb begin
        for (int k = 0; k < NE; k++) begin
            o_inv[k] = r_inv[k];
        end
    end
endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import mi3_pkg::*;

    typedef struct {
        logic [OW-1:0] inv [NE];
        logic          singular;
    } t_inverse;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [167:0] i_s_axis_tdata;   // m00,m01,m02,m10,m11,m12,m20,m21,m22, pad
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [287:0] o_m_axis_tdata;   // inv00..inv22
    logic         o_m_axis_tuser;   // singular
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;

    matrix3x3_inverse u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    localparam logic [17:0] EMAX = 18'h1FFFF;
    localparam logic [17:0] EMIN = 18'h20000;
    localparam logic [17:0] ONE  = 18'h10000;
    localparam int WATCHDOG = 20000;

    logic [15:0] threshold;
    t_inverse    inverse_queue [$];
    int          errors;
    int          n_results;
    int          n_singular;
    int          idle_cycles;
    bit          calm;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Rounded, saturated num * 2^32 / den
    function automatic logic [OW-1:0] quotient_q16(longint num, longint den);
        logic          neg;
        logic [127:0]  n;
        logic [127:0]  d;
        logic [127:0]  q;
        logic [127:0]  r;
        logic [127:0]  lim;
        begin
            neg = (num < 0) != (den < 0);
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            q = (n << 32) / d;
            r = (n << 32) % d;
            if (r >= d - r) q = q + 1;
            if (q > lim) q = lim;
            if (neg) q = -q;
            return q[31:0];
        end
    endfunction

    function automatic t_inverse invert(logic [167:0] data);
        longint   m [NE];
        longint   c [NE];
        longint   det;
        longint   adet;
        t_inverse res;
        begin
            for (int i = 0; i < NE; i++) m[i] = longint'($signed(data[18*i +: 18]));
            c[0] = m[4]*m[8] - m[5]*m[7];
            c[1] = m[2]*m[7] - m[1]*m[8];
            c[2] = m[1]*m[5] - m[2]*m[4];
            c[3] = m[5]*m[6] - m[3]*m[8];
            c[4] = m[0]*m[8] - m[2]*m[6];
            c[5] = m[2]*m[3] - m[0]*m[5];
            c[6] = m[3]*m[7] - m[4]*m[6];
            c[7] = m[1]*m[6] - m[0]*m[7];
            c[8] = m[0]*m[4] - m[1]*m[3];
            det = m[0]*c[0] + m[1]*c[3] + m[2]*c[6];
            adet = det < 0 ? -det : det;
            res.singular = (det == 0) || (adet < (longint'(threshold) << 16));
            for (int i = 0; i < NE; i++)
                res.inv[i] = res.singular ? '0 : quotient_q16(c[i], det);
            return res;
        end
    endfunction

    function automatic logic [167:0] pack9(logic [17:0] a0, logic [17:0] a1,
            logic [17:0] a2, logic [17:0] a3, logic [17:0] a4, logic [17:0] a5,
            logic [17:0] a6, logic [17:0] a7, logic [17:0] a8);
        return {6'd0, a8, a7, a6, a5, a4, a3, a2, a1, a0};
    endfunction

    function automatic logic [167:0] random_matrix();
        logic [167:0] d;
        int           kind;
        begin
            d = '0;
            kind = $urandom_range(0, 9);
            for (int i = 0; i < NE; i++) begin
                if (kind < 5) d[18*i +: 18] = 18'($urandom);
                else if (kind < 8)  // rotation-like: small entries
                    d[18*i +: 18] = 18'($signed($urandom_range(0, 131072)) - 65536);
                else d[18*i +: 18] = $urandom_range(0, 3) == 0 ? EMIN :
                    ($urandom_range(0, 2) == 0 ? EMAX : 18'($urandom_range(0, 15)));
            end
            // sometimes force a dependent row
            if ($urandom_range(0, 9) == 0) d[108 +: 54] = d[0 +: 54];
            return d;
        end
    endfunction

    // Send one matrix, with random gaps before the transfer; valid stays up after it
    task automatic send(logic [167:0] data);
        while (!calm && $urandom_range(0, 99) < 27) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        inverse_queue.push_back(invert(data));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic set_threshold(logic [15:0] value);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        threshold = value;
    endtask

    // Random stall on the result side
    always @(posedge i_clk)
        i_m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 27);

    // Check results against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_inverse e;
            if (inverse_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_m_axis_tdata);
                errors++;
            end else begin
                e = inverse_queue.pop_front();
                n_results++;
                if (e.singular) n_singular++;
                if (o_m_axis_tuser !== e.singular) begin
                    $display("%0t: singular expected %b actual %b", $time,
                             e.singular, o_m_axis_tuser);
                    errors++;
                end
                for (int i = 0; i < NE; i++)
                    if (o_m_axis_tdata[32*i +: 32] !== e.inv[i]) begin
                        $display("%0t: inv[%0d] expected %h actual %h", $time, i,
                                 e.inv[i], o_m_axis_tdata[32*i +: 32]);
                        errors++;
                    end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // Directed rows: matrix, whether the expectation is obvious, expected singular flag and inv00
    typedef struct {
        logic [167:0] data;
        bit           known;
        bit           singular;
        logic [31:0]  diag;
    } t_row;

    initial begin
        t_row rows [$];
        t_inverse e;
        logic [15:0] settings [5];
        errors = 0;
        n_results = 0;
        n_singular = 0;
        idle_cycles = 0;
        calm = 1'b0;
        threshold = THR_RESET;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity inverts to identity, zero and dependent rows are singular
        rows.push_back('{pack9(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1, 0, 32'h0001_0000});
        rows.push_back('{'0, 1, 1, 32'h0});
        rows.push_back('{pack9(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX),
                         1, 1, 32'h0});
        rows.push_back('{pack9(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN),
                         1, 1, 32'h0});
        rows.push_back('{pack9(EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN), 0, 0, 0});
        rows.push_back('{pack9(EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX), 0, 0, 0});
        rows.push_back('{pack9(EMAX, EMIN, 0, EMIN, EMAX, 0, 0, 0, EMIN), 0, 0, 0});
        // tiny diagonal: determinant below the reset threshold, result singular
        rows.push_back('{pack9(18'd1, 0, 0, 0, 18'd1, 0, 0, 0, 18'd1), 0, 0, 0});
        rows.push_back('{pack9(18'd64, 0, 0, 0, 18'd64, 0, 0, 0, 18'd64), 0, 0, 0});
        rows.push_back('{pack9(18'd2, 18'd1, 0, 0, 18'd3, 18'd1, 18'd1, 0, 18'h3FFFF),
                         0, 0, 0});
        rows.push_back('{pack9(0, ONE, 0, 0, 0, ONE, ONE, 0, 0), 0, 0, 0});
        rows.push_back('{pack9(EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMIN, EMIN, EMAX),
                         0, 0, 0});
        foreach (rows[k]) begin
            send(rows[k].data);
            e = inverse_queue[$];
            if (rows[k].known && (e.singular !== rows[k].singular ||
                                  e.inv[0] !== rows[k].diag)) begin
                $display("%0t: row %0d expected singular %b diag %h actual %b %h",
                         $time, k, rows[k].singular, rows[k].diag, e.singular, e.inv[0]);
                errors++;
            end
        end

        // threshold sweep, extremes included; zero determinant stays singular at 0
        settings = '{16'd0, 16'hFFFF, 16'd1, 16'd43, 16'h8000};
        foreach (settings[s]) begin
            set_threshold(settings[s]);
            send('0);
            send(pack9(18'd1, 0, 0, 0, 18'd1, 0, 0, 0, 18'd1));
            send(pack9(18'd256, 0, 0, 0, 18'd256, 0, 0, 0, 18'd256));
            for (int n = 0; n < 285; n++) begin
                calm = (s == 2) && (n < 200);
                send(random_matrix());
            end
            calm = 1'b0;
            // hold the input until every result is back
            drain();
        end

        drain();
        $display("tb: %0d matrices checked, %0d singular, thresholds 0..65535",
                 n_results, n_singular);
        if (errors == 0 && inverse_queue.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
